>>> rtl/cs0m_pkg.sv
`timescale 1ns / 1ps

package cs0m_pkg;

   // String modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_8      = 2'd1;
   localparam logic [1:0] MODE_16     = 2'd2;
   localparam logic [1:0] MODE_REJECT = 2'd3;

   // Compression IDs
   localparam logic [7:0] CID_8  = 8'd8;
   localparam logic [7:0] CID_16 = 8'd16;

   // Modified UTF-8 byte forms
   localparam logic [7:0]  LEAD2     = 8'hC0;
   localparam logic [7:0]  LEAD3     = 8'hE0;
   localparam logic [7:0]  CONT      = 8'h80;
   localparam logic [15:0] ONE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_LIMIT = 16'h07FF;

   // One queued job: up to three character bytes, then an optional end word
   typedef struct packed {
      logic [15:0] ch;
      logic [1:0]  len;   // character bytes, 0..3
      logic        term;  // end word follows
      logic        err;   // end word is the rejection word
   } job_type;

   function automatic logic [1:0] char_len(input logic [15:0] ch);
      logic [1:0] n;
      if (ch != 16'd0 && ch < ONE_LIMIT) begin
         n = 2'd1;
      end else if (ch <= TWO_LIMIT) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

   function automatic logic [7:0] char_byte(input logic [15:0] ch, input logic [1:0] len,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = ch[7:0];
      case (len)
         2'd2: begin
            if (idx == 2'd0) b = LEAD2 | {3'b000, ch[10:6]};
            else             b = CONT | {2'b00, ch[5:0]};
         end
         2'd3: begin
            if (idx == 2'd0)      b = LEAD3 | {4'b0000, ch[15:12]};
            else if (idx == 2'd1) b = CONT | {2'b00, ch[11:6]};
            else                  b = CONT | {2'b00, ch[5:0]};
         end
         default: b = ch[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> rtl/cs0m_ifs.sv
`timescale 1ns / 1ps

interface cs0m_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first_of_string;
   logic       last_of_string;

   modport source (output valid, in_byte, first_of_string, last_of_string, input ready);
   modport sink   (input valid, in_byte, first_of_string, last_of_string, output ready);
endinterface

interface cs0m_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       status;
   logic       end_of_string;

   modport source (output valid, out_byte, status, end_of_string, input ready);
   modport sink   (input valid, out_byte, status, end_of_string, output ready);
endinterface

>>> rtl/cs0_to_modified_utf8_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Word
// req_if  | in  | in_byte[7:0], first_of_string, last_of_string
// rsp_if  | out | out_byte[7:0], status, end_of_string
//
// Takes one input word per cycle while the job queue has room; a word gives
// zero to four output words, one per cycle while rsp_if is ready, so the output
// side sets the rate.
// When idle, an accepted word goes through the job queue, then the output register.
// Reset clears string mode, held byte, queue and output register; no sweep.
// The queue (QUEUE_DEPTH jobs) and output register let either side stall
// on its own; input ready drops only when the queue is full.

module cs0_to_modified_utf8_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic         clock,
   input logic         reset,
   cs0m_req_if.sink    req_if,
   cs0m_rsp_if.source  rsp_if
);

   // front: tracks string mode and the pending UTF-16 high byte, and turns each
   // accepted word that gives output into one job (character bytes plus optional end word)
   logic              push, pop, full, empty;
   cs0m_pkg::job_type push_job, head_job;

   cs0m_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (full),
      .push       (push),
      .job        (push_job)
   );

   // jobs wait here; words that give no output never enter
   cs0m_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_job),
      .pop   (pop),
      .rdata (head_job),
      .full  (full),
      .empty (empty)
   );

   // back: walks the head job one output byte per unstalled cycle into the output reg
   cs0m_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head_job),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

>>> rtl/cs0m_front.sv
`timescale 1ns / 1ps

module cs0m_front (
   input  logic              clock,
   input  logic              reset,
   cs0m_req_if.sink          req,
   input  logic              queue_full,
   output logic              push,
   output cs0m_pkg::job_type job
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] hi_ff, hi_in;
   logic       hi_vld_ff, hi_vld_in;
   logic       accept;
   logic [15:0] ch;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      mode_in   = mode_ff;
      hi_in     = hi_ff;
      hi_vld_in = hi_vld_ff;
      ch        = {8'h00, req.in_byte};
      job       = '0;
      if (req.first_of_string) begin
         hi_vld_in = 1'b0;
         hi_in     = 8'h00;
         if (req.in_byte == cs0m_pkg::CID_8 || req.in_byte == cs0m_pkg::CID_16) begin
            mode_in = (req.in_byte == cs0m_pkg::CID_8) ? cs0m_pkg::MODE_8 : cs0m_pkg::MODE_16;
            if (req.last_of_string) begin
               job.term = 1'b1;
               mode_in  = cs0m_pkg::MODE_IDLE;
            end
         end else begin
            job.term = 1'b1;
            job.err  = 1'b1;
            mode_in  = req.last_of_string ? cs0m_pkg::MODE_IDLE : cs0m_pkg::MODE_REJECT;
         end
      end else begin
         unique case (mode_ff)
            cs0m_pkg::MODE_8: begin
               job.len = cs0m_pkg::char_len(ch);
            end
            cs0m_pkg::MODE_16: begin
               if (hi_vld_ff) begin
                  ch        = {hi_ff, req.in_byte};
                  job.len   = cs0m_pkg::char_len(ch);
                  hi_vld_in = 1'b0;
                  hi_in     = 8'h00;
               end else begin
                  hi_in     = req.in_byte;
                  hi_vld_in = 1'b1;
               end
            end
            cs0m_pkg::MODE_REJECT: begin
               if (req.last_of_string) mode_in = cs0m_pkg::MODE_IDLE;
            end
            default: ;
         endcase
         if (req.last_of_string &&
             (mode_ff == cs0m_pkg::MODE_8 || mode_ff == cs0m_pkg::MODE_16)) begin
            job.term  = 1'b1;
            mode_in   = cs0m_pkg::MODE_IDLE;
            hi_vld_in = 1'b0;
            hi_in     = 8'h00;
         end
      end
      job.ch = ch;
   end

   assign push = accept && (job.len != 2'd0 || job.term);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cs0m_pkg::MODE_IDLE;
         hi_ff     <= 8'h00;
         hi_vld_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         hi_ff     <= hi_in;
         hi_vld_ff <= hi_vld_in;
      end
   end

`ifndef ASSERT_OFF
   // a held high byte only exists inside a 16-bit string
   a_hi_mode: assert property (@(posedge clock) disable iff (reset)
      hi_vld_ff |-> mode_ff == cs0m_pkg::MODE_16)
      else $error("held high byte outside 16-bit mode");
`endif

endmodule

>>> rtl/cs0m_fifo.sv
`timescale 1ns / 1ps

module cs0m_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cs0m_pkg::job_type wdata,
   input  logic              pop,
   output cs0m_pkg::job_type rdata,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cs0m_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == FULL_CNT;
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("queue overflow");
`endif

endmodule

>>> rtl/cs0m_back.sv
`timescale 1ns / 1ps

module cs0m_back (
   input  logic              clock,
   input  logic              reset,
   input  cs0m_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   cs0m_rsp_if.source        rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       st_ff, st_in;
   logic       eos_ff, eos_in;
   logic       load, take, char_step, final_step;

   assign load       = !vld_ff || rsp.ready;
   assign take       = load && !empty;
   assign char_step  = idx_ff < head.len;
   // last word of a job: end word if any, else the last character byte
   assign final_step = head.term ? !char_step : (idx_ff == head.len - 2'd1);
   assign pop        = take && final_step;

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      byte_in = byte_ff;
      st_in   = st_ff;
      eos_in  = eos_ff;
      if (take) begin
         vld_in = 1'b1;
         idx_in = final_step ? 2'd0 : idx_ff + 2'd1;
         if (char_step) begin
            byte_in = cs0m_pkg::char_byte(head.ch, head.len, idx_ff);
            st_in   = 1'b0;
            eos_in  = 1'b0;
         end else begin
            byte_in = 8'h00;
            st_in   = head.err;
            eos_in  = 1'b1;
         end
      end else if (rsp.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      st_ff   <= st_in;
      eos_ff  <= eos_in;
   end

   assign rsp.valid         = vld_ff;
   assign rsp.out_byte      = byte_ff;
   assign rsp.status        = st_ff;
   assign rsp.end_of_string = eos_ff;

`ifndef ASSERT_OFF
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && st_ff) |-> (eos_ff && byte_ff == 8'h00))
      else $error("rejection word malformed");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, idx_ff} < {1'b0, head.len} + {2'b00, head.term}))
      else $error("byte index past end of job");
`endif

endmodule
